FILE: src/ogpd_pkg.sv
// Shared types and constants for the Ogg page packet deframer.
`timescale 1ns / 1ps

package ogpd_pkg;

  localparam int HEADER_BYTES = 27;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  localparam int GRAN_FIRST = 6;
  localparam int GRAN_BYTES = 8;

  localparam logic [7:0] CONT_LACING = 8'd255;

  typedef enum logic [1:0] {
    KIND_DESC    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] packet_length;
    logic        packet_complete;
    logic [63:0] granule_position;
    logic        page_end;
  } result_t;

endpackage

FILE: src/ogpd_core.sv
// Page parser state and per-byte step logic.
`timescale 1ns / 1ps

module ogpd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  output logic             res_valid,
  output ogpd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LACING  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t                          phase, phase_next;
  logic [ogpd_pkg::HDR_IDX_W-1:0]  hdr_idx, hdr_idx_next;
  logic [7:0]                      seg_total, seg_total_next;
  logic [7:0]                      seg_index, seg_index_next;
  logic [15:0]                     pkt_acc, pkt_acc_next;
  logic [15:0]                     pay_rem, pay_rem_next;
  logic [63:0]                     granule, granule_next;

  logic        seg_last;
  logic [15:0] acc_sum;
  logic [15:0] rem_sum;
  logic [15:0] rem_dec;
  logic [63:0] gran_base;

  assign seg_last = ({1'b0, seg_index} + 9'd1) >= {1'b0, seg_total};
  assign acc_sum  = pkt_acc + {8'd0, data_byte};
  assign rem_sum  = pay_rem + {8'd0, data_byte};
  assign rem_dec  = (pay_rem != 16'd0) ? pay_rem - 16'd1 : pay_rem;

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    seg_total_next = seg_total;
    seg_index_next = seg_index;
    pkt_acc_next   = pkt_acc;
    pay_rem_next   = pay_rem;
    granule_next   = granule;
    gran_base      = granule;
    res_valid      = 1'b0;
    res            = '0;

    case (phase)
      PH_LACING: begin
        pkt_acc_next   = acc_sum;
        pay_rem_next   = rem_sum;
        seg_index_next = seg_index + 8'd1;
        if (data_byte != ogpd_pkg::CONT_LACING || seg_last) begin
          res_valid           = 1'b1;
          res.kind            = ogpd_pkg::KIND_DESC;
          res.packet_length   = acc_sum;
          res.packet_complete = (data_byte != ogpd_pkg::CONT_LACING);
          res.page_end        = seg_last && (rem_sum == 16'd0);
          pkt_acc_next        = 16'd0;
        end
        if (seg_last) begin
          phase_next = (rem_sum != 16'd0) ? PH_PAYLOAD : PH_HEADER;
        end
      end
      PH_PAYLOAD: begin
        pay_rem_next     = rem_dec;
        res_valid        = 1'b1;
        res.kind         = ogpd_pkg::KIND_PAYLOAD;
        res.payload_byte = data_byte;
        res.page_end     = (rem_dec == 16'd0);
        if (rem_dec == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // Header walk; an unused phase code lands here as well.
        phase_next = PH_HEADER;
        if (hdr_idx == '0) begin
          gran_base = 64'd0;
        end
        granule_next = gran_base;
        for (int k = 0; k < ogpd_pkg::GRAN_BYTES; k++) begin
          if (hdr_idx == ogpd_pkg::HDR_IDX_W'(ogpd_pkg::GRAN_FIRST + k)) begin
            granule_next[8*k +: 8] = gran_base[8*k +: 8] | data_byte;
          end
        end
        if (hdr_idx != ogpd_pkg::HDR_IDX_LAST) begin
          hdr_idx_next = hdr_idx + 1'b1;
        end else begin
          // Segment count byte; a byte never exceeds the segment cap.
          hdr_idx_next   = '0;
          seg_total_next = data_byte;
          seg_index_next = 8'd0;
          pkt_acc_next   = 16'd0;
          pay_rem_next   = 16'd0;
          if (data_byte == 8'd0) begin
            res_valid    = 1'b1;
            res.kind     = ogpd_pkg::KIND_EMPTY;
            res.page_end = 1'b1;
          end else begin
            phase_next = PH_LACING;
          end
        end
      end
    endcase

    res.granule_position = granule_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_idx   <= '0;
      seg_total <= 8'd0;
      seg_index <= 8'd0;
      pkt_acc   <= 16'd0;
      pay_rem   <= 16'd0;
      granule   <= 64'd0;
    end else if (step) begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      seg_total <= seg_total_next;
      seg_index <= seg_index_next;
      pkt_acc   <= pkt_acc_next;
      pay_rem   <= pay_rem_next;
      granule   <= granule_next;
    end
  end

endmodule

FILE: src/ogpd_stream.sv
// Input register and result register around the page parser.
`timescale 1ns / 1ps

module ogpd_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_req_valid,
  input  logic [7:0]  in_req_byte,
  output logic        in_req_ready,
  output logic        out_req_valid,
  input  logic        out_req_ready,
  output ogpd_pkg::result_t out_req
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              core_step;
  logic              res_valid;
  ogpd_pkg::result_t res;
  logic              out_valid;
  ogpd_pkg::result_t out_res;

  assign core_step     = in_valid && (!out_valid || out_req_ready);
  assign in_req_ready  = !in_valid || core_step;
  assign out_req_valid = out_valid;
  assign out_req       = out_res;

  ogpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (core_step),
    .data_byte (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_req_ready) begin
      in_valid <= in_req_valid;
    end
    if (in_req_ready && in_req_valid) begin
      in_byte <= in_req_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_step) begin
      out_valid <= res_valid;
    end else if (out_req_ready) begin
      out_valid <= 1'b0;
    end
    if (core_step && res_valid) begin
      out_res <= res;
    end
  end

  // A held byte must not be lost or altered while the result side stalls.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !core_step |=> in_valid && in_byte == $past(in_byte))
    else $error("held input byte lost");

  // A result waiting on the output must not be overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_req_ready |=> out_valid && out_res == $past(out_res))
    else $error("pending result overwritten");

endmodule

FILE: src/ogg_page_packet_deframer_unit.sv
// Top level of the Ogg page packet deframer.
`timescale 1ns / 1ps
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tdata[7:0] data_byte
// m_*      out  m_tvalid/m_tready  tuser kind, tlast page_end, tdata descriptor/payload
//
// One byte per cycle sustained while m_tready is not held low; a request is
// taken into the input register, stepped by the parser into the result
// register and then shown on the master side. The parser step that updates
// the page state is combinational between the input and result registers.
// Reset (rst, synchronous) clears both register valids and the parser state;
// no stores need a clearing pass. A stall on m_tready holds the pending
// result, and the input register can take one more byte if empty, then holds it.

module ogg_page_packet_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [7:0] payload_byte, [23:8] packet_length,
                                 // [24] packet_complete, [88:25] granule_position,
                                 // [95:89] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // page_end
);

  ogpd_pkg::result_t out_req;

  // Hold each byte in the input register, step the parser, register the result.
  ogpd_stream u_stream (
    .clk           (clk),
    .rst           (rst),
    .in_req_valid  (s_tvalid),
    .in_req_byte   (s_tdata),
    .in_req_ready  (s_tready),
    .out_req_valid (m_tvalid),
    .out_req_ready (m_tready),
    .out_req       (out_req)
  );

  // Pack the result fields, lowest first, zero fill to whole bytes.
  assign m_tdata = {7'd0, out_req.granule_position, out_req.packet_complete,
                    out_req.packet_length, out_req.payload_byte};
  assign m_tuser = out_req.kind;
  assign m_tlast = out_req.page_end;

  // An empty page marker always closes its page.
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ogpd_pkg::KIND_EMPTY |-> m_tlast)
    else $error("empty page marker without page end");

  // Payload requests carry no packet length or complete flag.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ogpd_pkg::KIND_PAYLOAD |-> m_tdata[24:8] == 17'd0)
    else $error("payload request with descriptor fields set");

endmodule
